/* hw/rtl/key_value_integer_scanner_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the key/value integer scanner
// Concurrent assertions that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_INTEGER_SCANNER_ASSERT_SVH
`define KEY_VALUE_INTEGER_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define KVIS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define KVIS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVIS_ASSERT(label, clk, rst, prop, msg)
`define KVIS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* hw/rtl/kvis_pkg.sv */
// ---------------------------------------------------------------------------
// kvis_pkg
// Types, character codes and per-character word functions of the scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package kvis_pkg;

   localparam int MAX_KEY_LEN = 16;

   // scan phases: even = between words, odd = inside a word
   localparam logic [2:0] PH_KEY_GAP  = 3'd0;
   localparam logic [2:0] PH_KEY_WORD = 3'd1;
   localparam logic [2:0] PH_EQ_GAP   = 3'd2;
   localparam logic [2:0] PH_EQ_WORD  = 3'd3;
   localparam logic [2:0] PH_VAL_GAP  = 3'd4;
   localparam logic [2:0] PH_VAL_WORD = 3'd5;

   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NO_EQ     = 2'd1;
   localparam logic [1:0] ST_NO_VALUE  = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic [1:0] REG_KEY_LOW  = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH = 2'd1;
   localparam logic [1:0] REG_KEY_LEN  = 2'd2;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_VT    = 8'h0b;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_EQUAL = 8'h3d;
   localparam logic [7:0] CH_BRACE = 8'h7b;

   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
      logic [4:0]  len;
   } key_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [4:0]  idx;
      logic        match;
      logic [31:0] acc;
      logic        neg;
      logic        stop;
   } word_type;

   typedef struct packed {
      logic        emit;
      logic [1:0]  status;
      logic [31:0] value;
   } res_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic        emit;
      logic [1:0]  status;
      logic [31:0] value;
   } end_type;

   function automatic logic is_end_char(input logic [7:0] b);
      logic r;
      case (b) inside
         CH_SPACE, CH_BS, CH_TAB, CH_LF, CH_CR, CH_COMMA, CH_QUOTE: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_gap_char(input logic [7:0] b);
      return is_end_char(b) || (b == CH_BRACE);
   endfunction

   function automatic word_type word_begin(input word_type w);
      word_type r;
      r       = w;
      r.phase = w.phase + 3'd1;
      r.idx   = '0;
      r.match = 1'b1;
      r.acc   = '0;
      r.neg   = 1'b0;
      r.stop  = 1'b0;
      return r;
   endfunction

   function automatic logic [7:0] key_byte(input key_type k, input logic [3:0] idx);
      logic [7:0] r;
      if (!idx[3]) r = k.low[8*idx[2:0] +: 8];
      else         r = k.high[8*idx[2:0] +: 8];
      return r;
   endfunction

   function automatic word_type word_char(input word_type w, input logic [7:0] b,
                                          input key_type k);
      word_type    r;
      logic [35:0] m;
      r = w;
      m = ({4'b0, w.acc} << 3) + ({4'b0, w.acc} << 1) + {32'b0, b[3:0]};
      if (w.phase == PH_KEY_WORD) begin
         if (w.idx < k.len && w.idx < 5'(MAX_KEY_LEN)) begin
            if (key_byte(k, w.idx[3:0]) != b) r.match = 1'b0;
         end else begin
            r.match = 1'b0;
         end
         if (w.idx != 5'd31) r.idx = w.idx + 5'd1;
      end else if (w.phase == PH_EQ_WORD) begin
         if (w.idx != 5'd0 || b != CH_EQUAL) r.match = 1'b0;
         if (w.idx != 5'd31) r.idx = w.idx + 5'd1;
      end else if (!w.stop) begin
         if (w.idx == 5'd0 && (b == CH_VT || b == CH_FF)) begin
            r = w;  // leading VT/FF skipped
         end else if (w.idx == 5'd0 && (b == CH_PLUS || b == CH_MINUS)) begin
            r.neg = (b == CH_MINUS);
            r.idx = 5'd1;
         end else if (b >= CH_ZERO && b <= CH_NINE) begin
            r.acc = (m > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : m[31:0];
            r.idx = 5'd1;
         end else begin
            r.stop = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic end_type word_end(input word_type w, input key_type k);
      end_type r;
      r.phase  = w.phase;
      r.emit   = 1'b0;
      r.status = ST_FOUND;
      r.value  = '0;
      if (w.phase == PH_KEY_WORD) begin
         r.phase = (w.match && w.idx == k.len && k.len >= 5'd1 &&
                    k.len <= 5'(MAX_KEY_LEN)) ? PH_EQ_GAP : PH_KEY_GAP;
      end else if (w.phase == PH_EQ_WORD) begin
         if (w.match && w.idx == 5'd1) begin
            r.phase = PH_VAL_GAP;
         end else begin
            r.emit   = 1'b1;
            r.status = ST_NO_EQ;
         end
      end else begin
         r.emit  = 1'b1;
         r.value = w.neg ? (32'd0 - w.acc) : (w.acc[31] ? POS_MAX : w.acc);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/key_value_integer_scanner.sv */
// ---------------------------------------------------------------------------
// key_value_integer_scanner
// Finds "key = value" in a character stream and returns the value as int32.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one text character per request, req_last_byte
//   marks the final character of a text. Result channel (rsp_*): exactly one
//   result per text, given at the character that decides it or at the last.
//   Configuration (APB, 64-bit data): key_chars_low at 0x00, key_chars_high
//   at 0x08, key_length at 0x10. Write only while the scanner is idle.
// Timing:
//   One request accepted per cycle while req_stall is low. A request is scanned
//   while it sits in the input register; its result is then registered in the
//   result register, which drives rsp_*.
//   The scan state is updated by combinational logic for each character.
// Stall:
//   While a result waits under rsp_stall, one more request is taken into the
//   input register, then req_stall rises until the result is taken.
// Reset:
//   Synchronous; clears the scan state and the key registers (key_length 1).
//   After the last character of a text the scan state rearms by itself.
// ---------------------------------------------------------------------------
`default_nettype none
`include "key_value_integer_scanner_assert.svh"

module key_value_integer_scanner
   import kvis_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic signed [31:0] rsp_value,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic      [63:0] prdata,
   output logic             pready
);

   key_type key;
   res_type res;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic        s1_go;
   logic        req_take;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_value_ff;

   kvis_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   // input stage advances whenever the result register is free or draining
   assign s1_go     = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   kvis_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_valid_ff && s1_go),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .key       (key),
      .res       (res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take)   s1_valid_in = 1'b1;
      else if (s1_go) s1_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && s1_go && res.emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall)                  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
      if (s1_valid_ff && s1_go && res.emit) begin
         rsp_status_ff <= res.status;
         rsp_value_ff  <= res.value;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = signed'(rsp_value_ff);

   `KVIS_ASSERT(a_stall_cause, clock, reset,
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall,
      "request stalled without a blocked result")
   `KVIS_ASSERT(a_s1_hold, clock, reset,
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_byte_ff),
      "input stage lost a blocked request")
   `KVIS_ASSERT(a_value_zero, clock, reset,
      rsp_valid && rsp_status != ST_FOUND |-> rsp_value == 32'sd0,
      "nonzero value on a failure status")
   `KVIS_ASSERT_ALWAYS(a_reset_idle, clock,
      $past(reset) |-> !rsp_valid_ff && !s1_valid_ff,
      "pipeline busy after reset")

endmodule

`default_nettype wire

/* hw/rtl/kvis_csr.sv */
// ---------------------------------------------------------------------------
// kvis_csr
// APB-style register file holding the search key and its length.
// ---------------------------------------------------------------------------
`default_nettype none

module kvis_csr
   import kvis_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic      [63:0] prdata,
   output logic             pready,
   output key_type          key
);

   logic [63:0] key_low_ff,  key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic [4:0]  key_len_ff,  key_len_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[4:3];

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      key_len_in  = key_len_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_KEY_LOW:  key_low_in  = pwdata;
            REG_KEY_HIGH: key_high_in = pwdata;
            REG_KEY_LEN:  key_len_in  = pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KEY_LOW:  prdata = key_low_ff;
         REG_KEY_HIGH: prdata = key_high_ff;
         REG_KEY_LEN:  prdata = {59'b0, key_len_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= 5'd1;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_len_ff  <= key_len_in;
      end
   end

   assign key.low  = key_low_ff;
   assign key.high = key_high_ff;
   assign key.len  = key_len_ff;

endmodule

`default_nettype wire

/* hw/rtl/kvis_scan.sv */
// ---------------------------------------------------------------------------
// kvis_scan
// Per-character scan state and its combinational update for one request.
// ---------------------------------------------------------------------------
`default_nettype none
`include "key_value_integer_scanner_assert.svh"

module kvis_scan
   import kvis_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   input  wire key_type    key,
   output res_type         res
);

   word_type word_ff, word_in;
   logic     comment_ff, comment_in;
   logic     slash_ff,   slash_in;
   logic     cr_ff,      cr_in;
   logic     given_ff,   given_in;

   word_type w_slash;
   word_type w_last;
   end_type  e_step;
   end_type  e_slash;
   end_type  e_last;
   logic [2:0] phase_fin;
   logic       given_mid;

   always_comb begin
      word_in    = word_ff;
      comment_in = comment_ff;
      slash_in   = slash_ff;
      cr_in      = cr_ff;
      res.emit   = 1'b0;
      res.status = ST_FOUND;
      res.value  = '0;

      e_step  = word_end(word_ff, key);
      w_slash = word_char(word_begin(word_ff), CH_SLASH, key);
      e_slash = word_end(w_slash, key);

      if (!given_ff) begin
         if (word_ff.phase[0]) begin
            if (is_end_char(data_byte)) begin
               word_in.phase = e_step.phase;
               res           = '{e_step.emit, e_step.status, e_step.value};
            end else begin
               word_in = word_char(word_ff, data_byte, key);
            end
         end else if (comment_ff) begin
            // comment closes on CR followed by LF
            if (cr_ff && data_byte == CH_LF) comment_in = 1'b0;
            cr_in = (data_byte == CH_CR);
         end else if (slash_ff) begin
            slash_in = 1'b0;
            if (data_byte == CH_SLASH) begin
               comment_in = 1'b1;
               cr_in      = 1'b0;
            end else if (is_end_char(data_byte)) begin
               word_in       = w_slash;
               word_in.phase = e_slash.phase;
               res           = '{e_slash.emit, e_slash.status, e_slash.value};
            end else begin
               word_in = word_char(w_slash, data_byte, key);
            end
         end else if (is_gap_char(data_byte)) begin
            word_in = word_ff;
         end else if (data_byte == CH_SLASH) begin
            slash_in = 1'b1;
         end else begin
            word_in = word_char(word_begin(word_ff), data_byte, key);
         end
      end

      given_mid = given_ff || res.emit;

      // end of text: close an open word, then report whatever is left
      w_last = word_in;
      if (!word_in.phase[0] && slash_in) w_last = word_char(word_begin(word_in), CH_SLASH, key);
      e_last    = word_end(w_last, key);
      phase_fin = w_last.phase[0] ? e_last.phase : w_last.phase;

      if (last_byte && !given_mid) begin
         res.emit = 1'b1;
         if (w_last.phase[0] && e_last.emit) begin
            res.status = e_last.status;
            res.value  = e_last.value;
         end else begin
            res.value = '0;
            if (phase_fin == PH_KEY_GAP)     res.status = ST_NOT_FOUND;
            else if (phase_fin == PH_EQ_GAP) res.status = ST_NO_EQ;
            else                             res.status = ST_NO_VALUE;
         end
      end

      given_in = given_mid || res.emit;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         word_ff.phase <= PH_KEY_GAP;
         word_ff.idx   <= '0;
         word_ff.match <= 1'b1;
         word_ff.acc   <= '0;
         word_ff.neg   <= 1'b0;
         word_ff.stop  <= 1'b0;
         comment_ff    <= 1'b0;
         slash_ff      <= 1'b0;
         cr_ff         <= 1'b0;
         given_ff      <= 1'b0;
      end else if (step) begin
         word_ff    <= word_in;
         comment_ff <= comment_in;
         slash_ff   <= slash_in;
         cr_ff      <= cr_in;
         given_ff   <= given_in;
      end
   end

   `KVIS_ASSERT(a_single_result, clock, reset, step && res.emit |-> !given_ff, "second result in one text")
   `KVIS_ASSERT(a_last_reports, clock, reset, step && last_byte && !given_ff |-> res.emit, "text ended without result")
   `KVIS_ASSERT(a_rearm, clock, reset, step && last_byte |=> !given_ff && word_ff.phase == PH_KEY_GAP, "scan state not rearmed")

endmodule

`default_nettype wire

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// tb - key/value integer scanner testbench
// Streams short texts through the scanner under a series of key settings and
// checks each status/value result against a cycle-free scan model kept in a
// small scoreboard. Both channels idle and stall at random; one phase holds
// results back long enough to back up the request channel.
// ---------------------------------------------------------------------------
module tb;
   import kvis_pkg::*;

   localparam int RANDOM_CHARS = 1500;
   localparam int PHASE_CHARS  = 180;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 3000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value;
   } scan_outcome_type;

   // Scan model plus the queue of results it has predicted.
   class kv_board;
      logic [63:0]      key_low;
      logic [63:0]      key_high;
      logic [4:0]       key_len;
      logic [2:0]       phase;
      logic [4:0]       pos;
      logic [31:0]      magnitude;
      bit               in_comment, slash_seen, prev_cr;
      bit               word_ok, minus, halted, answered;
      scan_outcome_type outcome_q[$];
      int               mismatches, checked, found_count;

      function new();
         key_low     = '0;
         key_high    = '0;
         key_len     = 5'd1;
         mismatches  = 0;
         checked     = 0;
         found_count = 0;
         rearm();
      endfunction

      static function bit ends_word(logic [7:0] b);
         return b == CH_SPACE || b == CH_BS || b == CH_TAB || b == CH_LF ||
                b == CH_CR || b == CH_COMMA || b == CH_QUOTE;
      endfunction

      function void set_key_reg(logic [1:0] idx, logic [63:0] v);
         case (idx)
            REG_KEY_LOW:  key_low  = v;
            REG_KEY_HIGH: key_high = v;
            REG_KEY_LEN:  key_len  = v[4:0];
            default: ;
         endcase
      endfunction

      function void rearm();
         phase      = PH_KEY_GAP;
         in_comment = 0;
         slash_seen = 0;
         prev_cr    = 0;
         pos        = '0;
         word_ok    = 1;
         magnitude  = '0;
         minus      = 0;
         halted     = 0;
         answered   = 0;
      endfunction

      function void open_word();
         phase     = phase + 3'd1;
         pos       = '0;
         word_ok   = 1;
         magnitude = '0;
         minus     = 0;
         halted    = 0;
      endfunction

      function void post(logic [1:0] st, logic [31:0] v);
         scan_outcome_type o;
         o.status = st;
         o.value  = v;
         outcome_q.push_back(o);
         answered = 1;
      endfunction

      function void eat_char(logic [7:0] b);
         logic [63:0] m;
         logic [7:0]  kb;
         if (phase == PH_KEY_WORD) begin
            if (pos < key_len && pos < 5'(MAX_KEY_LEN)) begin
               kb = pos[3] ? key_high[8*pos[2:0] +: 8] : key_low[8*pos[2:0] +: 8];
               if (kb != b) word_ok = 0;
            end else begin
               word_ok = 0;
            end
            if (pos != 5'd31) pos = pos + 5'd1;
         end else if (phase == PH_EQ_WORD) begin
            if (pos != 5'd0 || b != CH_EQUAL) word_ok = 0;
            if (pos != 5'd31) pos = pos + 5'd1;
         end else if (!halted && !(pos == 5'd0 && (b == CH_VT || b == CH_FF))) begin
            if (pos == 5'd0 && (b == CH_PLUS || b == CH_MINUS)) begin
               minus = (b == CH_MINUS);
               pos   = 5'd1;
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
               m         = 64'(magnitude) * 64'd10 + 64'(b - CH_ZERO);
               magnitude = (m > 64'(MAG_LIMIT)) ? MAG_LIMIT : m[31:0];
               pos       = 5'd1;
            end else begin
               halted = 1;
            end
         end
      endfunction

      function void close_word();
         if (phase == PH_KEY_WORD) begin
            phase = (word_ok && pos == key_len && key_len >= 5'd1 &&
                     key_len <= 5'(MAX_KEY_LEN)) ? PH_EQ_GAP : PH_KEY_GAP;
         end else if (phase == PH_EQ_WORD) begin
            if (word_ok && pos == 5'd1) phase = PH_VAL_GAP;
            else post(ST_NO_EQ, '0);
         end else if (minus) begin
            post(ST_FOUND, 32'd0 - magnitude);
         end else begin
            post(ST_FOUND, magnitude[31] ? POS_MAX : magnitude);
         end
      endfunction

      function void note_char(logic [7:0] b, logic last);
         if (!answered) begin
            if (phase[0]) begin
               if (ends_word(b)) close_word();
               else eat_char(b);
            end else if (in_comment) begin
               if (prev_cr && b == CH_LF) in_comment = 0;
               prev_cr = (b == CH_CR);
            end else if (slash_seen) begin
               slash_seen = 0;
               if (b == CH_SLASH) begin
                  in_comment = 1;
                  prev_cr    = 0;
               end else begin
                  open_word();
                  eat_char(CH_SLASH);
                  if (ends_word(b)) close_word();
                  else eat_char(b);
               end
            end else if (b == CH_SLASH) begin
               slash_seen = 1;
            end else if (!ends_word(b) && b != CH_BRACE) begin
               open_word();
               eat_char(b);
            end
         end
         if (last) begin
            if (!answered) begin
               if (!phase[0] && slash_seen) begin
                  slash_seen = 0;
                  open_word();
                  eat_char(CH_SLASH);
               end
               if (phase[0]) close_word();
               if (!answered) begin
                  if (phase == PH_KEY_GAP) post(ST_NOT_FOUND, '0);
                  else if (phase == PH_EQ_GAP) post(ST_NO_EQ, '0);
                  else post(ST_NO_VALUE, '0);
               end
            end
            rearm();
         end
      endfunction

      function void check_result(logic [1:0] st, logic [31:0] v);
         scan_outcome_type e;
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result: status %0d value %0d",
                     $time, st, $signed(v));
            mismatches++;
            return;
         end
         e = outcome_q.pop_front();
         checked++;
         if (e.status == ST_FOUND) found_count++;
         if (st !== e.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, st);
            mismatches++;
         end
         if (v !== e.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, $signed(e.value), $signed(v));
            mismatches++;
         end
      endfunction
   endclass

   logic               clock, reset;
   logic               req_valid, req_stall, req_last_byte;
   logic [7:0]         req_data_byte;
   logic               rsp_valid, rsp_stall;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_value;
   logic               psel, penable, pwrite, pready;
   logic [4:0]         paddr;
   logic [63:0]        pwdata, prdata;

   kv_board    board;
   logic [7:0] text_q[$];
   logic [7:0] key_bytes[MAX_KEY_LEN];
   int         chars_sent, texts_sent, settings_used, idle_cycles;
   bit         calm, hold_now, hold_active;

   key_value_integer_scanner DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_value     (rsp_value),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_end();
      logic [7:0] r;
      case ($urandom_range(0, 6))
         0: r = CH_SPACE;
         1: r = CH_BS;
         2: r = CH_TAB;
         3: r = CH_LF;
         4: r = CH_CR;
         5: r = CH_COMMA;
         default: r = CH_QUOTE;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] pick_gap_char();
      return ($urandom_range(0, 7) == 0) ? CH_BRACE : pick_end();
   endfunction

   // a byte that stays inside a word; a word start must not be skipped or open a comment
   function automatic logic [7:0] word_byte(bit first);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (kv_board::ends_word(b) || (first && (b == CH_BRACE || b == CH_SLASH)));
      return b;
   endfunction

   task automatic add_byte(logic [7:0] b);
      text_q.push_back(b);
   endtask

   task automatic add_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic add_word(int n);
      for (int i = 0; i < n; i++) text_q.push_back(word_byte(i == 0));
   endtask

   task automatic add_key(int n);
      for (int i = 0; i < n; i++) text_q.push_back(key_bytes[i]);
   endtask

   task automatic add_value();
      int r, n;
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: add_str("2147483647");
            1: add_str("2147483648");
            2: add_str("-2147483648");
            default: add_str("-2147483649");
         endcase
      end else begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) add_byte($urandom_range(0, 1) ? CH_VT : CH_FF);
         r = $urandom_range(0, 9);
         if (r < 2) add_byte(CH_MINUS);
         else if (r == 2) add_byte(CH_PLUS);
         r = $urandom_range(0, 9);
         n = (r < 7) ? $urandom_range(1, 9) : (r < 9) ? $urandom_range(10, 12) : 0;
         repeat (n) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
         // a trailing byte stops the conversion unless it is a digit
         if ($urandom_range(0, 6) == 0) add_byte(word_byte(1'b0));
      end
   endtask

   // Mostly "key = value" with noise around it; some texts are cut short or broken.
   task automatic build_text(int klen);
      int kind;
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 4))
            0: add_word($urandom_range(1, 6));
            1: begin
               add_key(klen);
               add_byte(word_byte(1'b0));
            end
            2: if (klen > 1) add_key(klen - 1);
               else add_word(2);
            3: begin
               add_str("//");
               repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
               add_byte(CH_CR);
               add_byte(CH_LF);
            end
            default: begin
               add_byte(CH_SLASH);
               add_word($urandom_range(1, 3));
            end
         endcase
         add_byte(pick_end());
         if ($urandom_range(0, 2) == 0) add_byte(pick_gap_char());
      end
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         if (kind >= 96) add_str("//");
         repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
         return;
      end
      add_key(klen);
      if (kind >= 75 && kind < 80) begin
         if ($urandom_range(0, 1)) add_byte(pick_gap_char());
         return;
      end
      add_byte(pick_end());
      if ($urandom_range(0, 1)) add_byte(pick_gap_char());
      add_byte(CH_EQUAL);
      if (kind >= 85) add_byte($urandom_range(0, 1) ? CH_EQUAL : word_byte(1'b0));
      if (kind >= 80 && kind < 85) begin
         if ($urandom_range(0, 1)) add_byte(pick_end());
         return;
      end
      add_byte(pick_end());
      if ($urandom_range(0, 1)) add_byte(pick_gap_char());
      add_value();
      if ($urandom_range(0, 1)) begin
         add_byte(pick_end());
         repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_text();
      int gap;
      for (int i = 0; i < text_q.size(); i++) begin
         req_valid     <= 1'b1;
         req_data_byte <= text_q[i];
         req_last_byte <= (i == text_q.size() - 1);
         do @(posedge clock); while (req_stall);
         chars_sent++;
         gap = calm ? 0 : pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      texts_sent++;
      text_q.delete();
   endtask

   // stop sending and let every awaited result come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outcome_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.set_key_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic program_key(int len);
      logic [63:0] lo, hi;
      for (int i = 0; i < 8; i++) begin
         lo[8*i +: 8] = key_bytes[i];
         hi[8*i +: 8] = key_bytes[i + 8];
      end
      write_csr(REG_KEY_LOW, lo);
      write_csr(REG_KEY_HIGH, hi);
      write_csr(REG_KEY_LEN, 64'(len));
      settings_used++;
   endtask

   task automatic set_key_text(string s, int len);
      for (int i = 0; i < MAX_KEY_LEN; i++) key_bytes[i] = (i < s.len()) ? s[i] : 8'h00;
      program_key(len);
   endtask

   // result side: random stall stretches, or one long hold on request
   initial begin
      int stretch;
      bit hold;
      rsp_stall <= 1'b0;
      hold_active = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_now) begin
            hold_now    = 0;
            hold_active = 1;
            hold        = 1;
            stretch     = HOLD_CYCLES;
         end else begin
            hold_active = 0;
            hold        = calm ? 1'b0 : ($urandom_range(0, 3) == 0);
            stretch     = hold ? pick_gap() + 1 : $urandom_range(1, 8);
         end
         rsp_stall <= hold;
         repeat (stretch) @(posedge clock);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_char(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_status, rsp_value);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int rand_start, phase_start, phase_no, klen;
      board         = new();
      chars_sent    = 0;
      texts_sent    = 0;
      settings_used = 0;
      idle_cycles   = 0;
      calm          = 0;
      hold_now      = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key is a single NUL character
      add_byte(8'h00);
      add_str(" = +5");
      send_text();
      drain();
      set_key_text("k", 1);
      add_str("k\t= ");
      add_byte(CH_VT);
      add_str("-99999999999\r\n");
      send_text();
      add_str("// k = 1\r\nk,=\"99999999999");
      send_text();
      add_str("k");
      send_text();
      add_str("{k =");
      send_text();
      add_str("kk");
      send_text();
      add_str("k == 4");
      send_text();
      add_str("k = 12a9");
      send_text();
      add_str("k = +");
      send_text();
      add_str("/");
      send_text();
      add_str("//k = 1");
      send_text();
      drain();
      set_key_text("k", 0);
      add_str("k = 1");
      send_text();
      drain();

      rand_start = chars_sent;
      phase_no   = 0;
      while (chars_sent - rand_start < RANDOM_CHARS) begin
         case (phase_no)
            0: klen = 1;
            1: klen = MAX_KEY_LEN;
            2: klen = 0;
            3: klen = 31;
            4: klen = MAX_KEY_LEN + 1;
            default: klen = $urandom_range(1, MAX_KEY_LEN);
         endcase
         for (int i = 0; i < MAX_KEY_LEN; i++) key_bytes[i] = word_byte(i == 0);
         program_key(klen);
         calm        = (phase_no == 5);
         phase_start = chars_sent;
         while (chars_sent - phase_start < PHASE_CHARS) begin
            build_text((klen >= 1 && klen <= MAX_KEY_LEN) ? klen
                                                          : $urandom_range(1, MAX_KEY_LEN));
            send_text();
         end
         if (phase_no == 1) begin
            // early result held back while filler requests keep coming
            drain();
            hold_now = 1;
            wait (hold_active);
            calm = 1;
            add_key(klen);
            add_str(" = 5 ");
            repeat (30) add_byte(word_byte(1'b0));
            send_text();
            calm = 0;
         end
         drain();
         phase_no++;
      end

      $display("Scanned %0d characters in %0d texts under %0d key settings.",
               chars_sent, texts_sent, settings_used);
      $display("Checked %0d results (%0d with a parsed value), %0d mismatches.",
               board.checked, board.found_count, board.mismatches);
      if (board.mismatches == 0 && board.outcome_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
